// ===== sv/qpe_pkg.sv =====
`timescale 1ns / 1ps
package qpe_pkg;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_EQ     = 8'd61;
    localparam logic [7:0] PRINT_LO  = 8'd33;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [7:0] WIDTH_RST = 8'd76;

    // token kinds queued for output
    typedef enum logic [1:0] {
        TOK_SOFT,   // '=' CR LF
        TOK_LIT,    // the byte itself
        TOK_ESC,    // '=' hi lo
        TOK_CRLF    // CR LF
    } t_tok;

    // token slots: 0 soft break, 1 held whitespace, 2 soft break, 3 current byte
    typedef struct packed {
        logic [3:0] vld;
        t_tok       kind1;
        logic [7:0] byte1;
        t_tok       kind3;
        logic [7:0] byte3;
        logic       last;
        logic       held_n;
        logic       tab_n;
        logic [7:0] len_n;
    } t_plan;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (8'd48 + {4'd0, v}) : (8'd55 + {4'd0, v});
    endfunction

    function automatic logic [1:0] tok_last_sub(input t_tok k);
        case (k)
            TOK_SOFT: tok_last_sub = 2'd2;
            TOK_LIT:  tok_last_sub = 2'd0;
            TOK_ESC:  tok_last_sub = 2'd2;
            TOK_CRLF: tok_last_sub = 2'd1;
            default:  tok_last_sub = 2'd0;
        endcase
    endfunction

    function automatic logic [7:0] tok_char(input t_tok k, input logic [7:0] b,
                                            input logic [1:0] sub);
        logic [7:0] c;
        c = CH_EQ;
        case (k)
            TOK_SOFT: c = (sub == 2'd0) ? CH_EQ : ((sub == 2'd1) ? CH_CR : CH_LF);
            TOK_LIT:  c = b;
            TOK_ESC:  c = (sub == 2'd0) ? CH_EQ :
                          ((sub == 2'd1) ? hex_digit(b[7:4]) : hex_digit(b[3:0]));
            TOK_CRLF: c = (sub == 2'd0) ? CH_CR : CH_LF;
            default:  c = b;
        endcase
        tok_char = c;
    endfunction

endpackage

// ===== sv/qpe_plan.sv =====
`timescale 1ns / 1ps
module qpe_plan (
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    input  logic [7:0]     i_width,
    input  logic           i_held,
    input  logic           i_held_tab,
    input  logic [7:0]     i_len,
    output qpe_pkg::t_plan o_plan
);
    import qpe_pkg::*;

    logic       is_cr, is_lf, is_ws, is_print;
    logic [8:0] n1, sum1, n2, sum2;
    logic       brk1, brk2, fits, cur_vld;
    logic [7:0] len1, len2;
    t_tok       kind_cur;

    always_comb begin
        is_cr    = (i_in_byte == CH_CR);
        is_lf    = (i_in_byte == CH_LF);
        is_ws    = (i_in_byte == CH_SPACE) || (i_in_byte == CH_TAB);
        is_print = (i_in_byte >= PRINT_LO) && (i_in_byte <= PRINT_HI)
                   && (i_in_byte != CH_EQ);

        // held whitespace resolves against this byte
        n1   = (is_cr || is_lf) ? 9'd3 : 9'd1;
        sum1 = {1'b0, i_len} + n1;
        brk1 = i_held && (sum1 > {1'b0, i_width});
        len1 = i_held ? (brk1 ? n1[7:0] : sum1[7:0]) : i_len;

        // current byte
        cur_vld  = 1'b1;
        kind_cur = TOK_ESC;
        if (is_cr) begin
            cur_vld = 1'b0;
        end else if (is_lf) begin
            kind_cur = TOK_CRLF;
        end else if (is_ws) begin
            cur_vld  = i_in_last;
            kind_cur = TOK_LIT;
        end else if (is_print) begin
            kind_cur = TOK_LIT;
        end
        fits = cur_vld && (kind_cur != TOK_CRLF);
        n2   = (kind_cur == TOK_ESC) ? 9'd3 : 9'd1;
        sum2 = {1'b0, len1} + n2;
        brk2 = fits && (sum2 > {1'b0, i_width});
        if (is_lf)      len2 = 8'd0;
        else if (fits)  len2 = brk2 ? n2[7:0] : sum2[7:0];
        else            len2 = len1;

        o_plan.vld    = {cur_vld, brk2, i_held, brk1};
        o_plan.kind1  = (is_cr || is_lf) ? TOK_ESC : TOK_LIT;
        o_plan.byte1  = i_held_tab ? CH_TAB : CH_SPACE;
        o_plan.kind3  = kind_cur;
        o_plan.byte3  = i_in_byte;
        o_plan.last   = i_in_last;
        o_plan.held_n = is_ws && !i_in_last;
        o_plan.tab_n  = (i_in_byte == CH_TAB) && !i_in_last;
        o_plan.len_n  = i_in_last ? 8'd0 : len2;
    end

endmodule

// ===== sv/quoted_printable_encoder.sv =====
`timescale 1ns / 1ps
// quoted-printable body encoder, one raw text byte in, zero to ten ascii characters out
//
// input channel: i_valid / o_ready carry i_in_byte and i_in_last (last byte of a text)
// output channel: o_valid / i_ready carry o_out_byte, o_run_last (last character made
// by one input beat) and o_text_end (final character of the whole text)
// line width: i_line_width is written whenever i_line_width_we is high; change it only
// while the encoder is idle
//
// latency: an accepted beat is planned in the same cycle and its first character is
// shown on the output the next cycle
// throughput: one character leaves per cycle while i_ready is high; a beat makes 1
// character for a literal, 3 for an escape and up to 10 with soft breaks; a dropped
// CR or a held space leaves no character of its own; the next beat is taken in the
// cycle the last character of the previous one is taken
// reset: line width returns to 76, nothing is held, line length is zero, output empty
// stall: while i_ready is low the current character holds and o_ready stays low as long
// as any queued character remains
module quoted_printable_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_line_width_we,
    input  logic [7:0] i_line_width,
    // input beats
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // output beats
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_end
);
    import qpe_pkg::*;

    // encoder state carried between input beats
    logic [7:0] r_width;
    logic       r_held, r_held_tab;
    logic [7:0] r_len;

    // token queue of the beat being sent
    logic [3:0] r_vld, n_vld;
    logic [1:0] r_sub, n_sub;
    t_tok       r_kind1, r_kind3;
    logic [7:0] r_byte1, r_byte3;
    logic       r_last;

    t_plan      plan;
    logic       in_fire, out_fire;
    logic [1:0] cur;
    t_tok       cur_kind;
    logic [7:0] cur_byte;
    logic       sub_end, only_one;

    qpe_plan u_plan (
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_width    (r_width),
        .i_held     (r_held),
        .i_held_tab (r_held_tab),
        .i_len      (r_len),
        .o_plan     (plan)
    );

    // pick the lowest pending slot
    always_comb begin
        if (r_vld[0])      cur = 2'd0;
        else if (r_vld[1]) cur = 2'd1;
        else if (r_vld[2]) cur = 2'd2;
        else               cur = 2'd3;
        case (cur)
            2'd1:    begin cur_kind = r_kind1;  cur_byte = r_byte1; end
            2'd3:    begin cur_kind = r_kind3;  cur_byte = r_byte3; end
            default: begin cur_kind = TOK_SOFT; cur_byte = r_byte3; end
        endcase
        sub_end  = (r_sub == tok_last_sub(cur_kind));
        only_one = ((r_vld & (r_vld - 4'd1)) == 4'd0);
    end

    assign o_valid    = |r_vld;
    assign o_out_byte = tok_char(cur_kind, cur_byte, r_sub);
    assign o_run_last = sub_end && only_one;
    assign o_text_end = sub_end && only_one && r_last;

    assign out_fire = o_valid && i_ready;
    // free when empty or when the final character of the queue leaves now
    assign o_ready  = !o_valid || (i_ready && sub_end && only_one);
    assign in_fire  = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        n_sub = r_sub;
        if (out_fire) begin
            if (sub_end) begin
                n_vld[cur] = 1'b0;
                n_sub      = 2'd0;
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end
        if (in_fire) begin
            n_vld = plan.vld;
            n_sub = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RST;
            r_held     <= 1'b0;
            r_held_tab <= 1'b0;
            r_len      <= 8'd0;
            r_vld      <= 4'd0;
            r_sub      <= 2'd0;
        end else begin
            if (i_line_width_we) begin
                r_width <= i_line_width;
            end
            r_vld <= n_vld;
            r_sub <= n_sub;
            if (in_fire) begin
                r_held     <= plan.held_n;
                r_held_tab <= plan.tab_n;
                r_len      <= plan.len_n;
            end
        end
    end

    // payload of the queued beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind1 <= plan.kind1;
            r_byte1 <= plan.byte1;
            r_kind3 <= plan.kind3;
            r_byte3 <= plan.byte3;
            r_last  <= plan.last;
        end
    end

`ifndef SYNTHESIS
    // character index never runs past the current token
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sub <= tok_last_sub(cur_kind)))
        else $error("character index beyond token");

    // end of text is always the end of a beat
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_text_end |-> o_run_last)
        else $error("text end without run end");

    // a final byte leaves a fresh line and nothing held
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_last) |=> (r_len == 8'd0 && !r_held))
        else $error("state not cleared after last byte");

    // an empty queue always takes a beat
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty encoder refused input");
`endif

endmodule

// ===== tb/sv/qp_stream_checker.sv =====
`timescale 1ns / 1ps
// watches both channels of the encoder, predicts each encoded character and compares
module qp_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_width_we,
    input  logic [7:0] i_width,
    input  logic       i_raw_valid,
    input  logic       i_raw_ready,
    input  logic [7:0] i_raw_byte,
    input  logic       i_raw_last,
    input  logic       i_enc_valid,
    input  logic       i_enc_ready,
    input  logic [7:0] i_enc_byte,
    input  logic       i_enc_run_last,
    input  logic       i_enc_text_end,
    output int         o_pending,
    output int         o_fail_count
);
    import qpe_pkg::*;

    localparam int MAX_CHARS_PER_BEAT = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       text_end;
    } t_qp_char;

    // encoder state as predicted
    logic [7:0] line_width;
    logic       held_ws;
    logic       held_tab;
    logic [7:0] line_len;

    logic [7:0] beat_buf [MAX_CHARS_PER_BEAT];
    int         beat_len;
    t_qp_char   expected_chars [$];
    t_qp_char   want_char;
    int         mismatches;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        mismatches   = 0;
        beat_len     = 0;
        line_width   = WIDTH_RST;
        held_ws      = 1'b0;
        held_tab     = 1'b0;
        line_len     = 8'd0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t ns: mismatch, %s", $time, what);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h37 + 8'(nib));
    endfunction

    task automatic push_char(input logic [7:0] c);
        if (beat_len < MAX_CHARS_PER_BEAT) begin
            beat_buf[beat_len] = c;
            beat_len++;
        end
    endtask

    // soft break when the next token would overrun the line
    task automatic make_room(input int need);
        if (int'(line_len) + need > int'(line_width)) begin
            push_char(CH_EQ);
            push_char(CH_CR);
            push_char(CH_LF);
            line_len = 8'd0;
        end
    endtask

    task automatic put_literal(input logic [7:0] c);
        make_room(1);
        push_char(c);
        line_len = line_len + 8'd1;
    endtask

    task automatic put_escape(input logic [7:0] c);
        make_room(3);
        push_char(CH_EQ);
        push_char(hex_char(c[7:4]));
        push_char(hex_char(c[3:0]));
        line_len = line_len + 8'd3;
    endtask

    task automatic encode_beat(input logic [7:0] b, input logic last);
        t_qp_char c;
        beat_len = 0;
        // a held space or tab is escaped only before a line end
        if (held_ws) begin
            if (b == CH_CR || b == CH_LF) begin
                put_escape(held_tab ? CH_TAB : CH_SPACE);
            end else begin
                put_literal(held_tab ? CH_TAB : CH_SPACE);
            end
            held_ws  = 1'b0;
            held_tab = 1'b0;
        end
        if (b == CH_LF) begin
            push_char(CH_CR);
            push_char(CH_LF);
            line_len = 8'd0;
        end else if (b == CH_SPACE || b == CH_TAB) begin
            if (last) begin
                put_literal(b);
            end else begin
                held_ws  = 1'b1;
                held_tab = (b == CH_TAB);
            end
        end else if (b >= PRINT_LO && b <= PRINT_HI && b != CH_EQ) begin
            put_literal(b);
        end else if (b != CH_CR) begin
            put_escape(b);
        end
        if (last) begin
            held_ws  = 1'b0;
            held_tab = 1'b0;
            line_len = 8'd0;
        end
        for (int k = 0; k < beat_len; k++) begin
            c.ch       = beat_buf[k];
            c.run_last = (k == beat_len - 1);
            c.text_end = (k == beat_len - 1) && last;
            expected_chars.push_back(c);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_width = WIDTH_RST;
            held_ws    = 1'b0;
            held_tab   = 1'b0;
            line_len   = 8'd0;
            expected_chars.delete();
        end else begin
            if (i_width_we) begin
                line_width = i_width;
            end
            if (i_raw_valid && i_raw_ready) begin
                encode_beat(i_raw_byte, i_raw_last);
            end
            if (i_enc_valid && i_enc_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, char %02h", i_enc_byte));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (i_enc_byte !== want_char.ch) begin
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  i_enc_byte, want_char.ch));
                    end
                    if (i_enc_run_last !== want_char.run_last) begin
                        report_mismatch($sformatf("run_last got %b want %b, char %02h",
                                                  i_enc_run_last, want_char.run_last,
                                                  want_char.ch));
                    end
                    if (i_enc_text_end !== want_char.text_end) begin
                        report_mismatch($sformatf("text_end got %b want %b, char %02h",
                                                  i_enc_text_end, want_char.text_end,
                                                  want_char.ch));
                    end
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/quoted_printable_encoder_tb.sv =====
`timescale 1ns / 1ps
// top of the encoder regression: clock, reset, stimulus and the verdict
module quoted_printable_encoder_tb;
    import qpe_pkg::*;

    // generous ceiling: every beat at ten characters, each behind a long stall
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_width  = 8'd0;
    logic       raw_valid  = 1'b0;
    logic       raw_ready;
    logic [7:0] raw_byte   = 8'd0;
    logic       raw_last   = 1'b0;
    logic       enc_valid;
    logic       enc_ready  = 1'b0;
    logic [7:0] enc_byte;
    logic       enc_run_last;
    logic       enc_text_end;

    int         pending;
    int         fail_count;
    int         cycle_count = 0;
    int         ready_left  = 0;
    int         text_left   = 0;
    logic       gap_free    = 1'b0;   // sender never idles
    logic       sink_steady = 1'b0;   // receiver never stalls

    quoted_printable_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_width_we (cfg_we),
        .i_line_width    (cfg_width),
        .i_valid         (raw_valid),
        .o_ready         (raw_ready),
        .i_in_byte       (raw_byte),
        .i_in_last       (raw_last),
        .o_valid         (enc_valid),
        .i_ready         (enc_ready),
        .o_out_byte      (enc_byte),
        .o_run_last      (enc_run_last),
        .o_text_end      (enc_text_end)
    );

    qp_stream_checker u_qp_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_width_we     (cfg_we),
        .i_width        (cfg_width),
        .i_raw_valid    (raw_valid),
        .i_raw_ready    (raw_ready),
        .i_raw_byte     (raw_byte),
        .i_raw_last     (raw_last),
        .i_enc_valid    (enc_valid),
        .i_enc_ready    (enc_ready),
        .i_enc_byte     (enc_byte),
        .i_enc_run_last (enc_run_last),
        .i_enc_text_end (enc_text_end),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: runs of ready, short stalls, now and then a long one
    always @(posedge i_clk) begin
        int roll;
        if (!i_rst_n) begin
            enc_ready  <= 1'b0;
            ready_left <= 0;
        end else if (sink_steady) begin
            enc_ready  <= 1'b1;
            ready_left <= 0;
        end else if (ready_left == 0) begin
            roll = $urandom_range(0, 99);
            enc_ready <= (roll < 65);
            if (roll < 65) begin
                ready_left <= $urandom_range(1, 12);
            end else if (roll < 92) begin
                ready_left <= $urandom_range(1, 3);
            end else begin
                ready_left <= $urandom_range(10, 40);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_free || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // text-like bytes: printable runs, whitespace, line ends, plus raw noise
    function automatic logic [7:0] pick_text_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 8'($urandom_range(PRINT_LO, PRINT_HI));
        end else if (roll < 65) begin
            return CH_SPACE;
        end else if (roll < 70) begin
            return CH_TAB;
        end else if (roll < 76) begin
            return CH_LF;
        end else if (roll < 80) begin
            return CH_CR;
        end else if (roll < 84) begin
            return CH_EQ;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one input beat; entered and left at a rising edge, valid held until taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            raw_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        raw_valid <= 1'b1;
        raw_byte  <= b;
        raw_last  <= last;
        do @(posedge i_clk); while (!raw_ready);
    endtask

    // random texts of random length, the last byte of each flagged
    task automatic send_text(input int count);
        logic [7:0] b;
        repeat (count) begin
            b = pick_text_byte();
            if (text_left == 0) begin
                text_left = $urandom_range(3, 40);
            end
            text_left--;
            send_beat(b, text_left == 0);
        end
    endtask

    // sender stops until every predicted character is out, then waits further to let
    // a dropped cr or held space still inside the encoder settle
    task automatic drain_and_settle();
        raw_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [7:0] w);
        cfg_we    <= 1'b1;
        cfg_width <= w;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [7:0] phase_width [PHASES];
        phase_width = '{8'd4, 8'd255, WIDTH_RST, 8'd0, 8'd0, 8'd5};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats at the reset line width
        send_beat(8'h41, 1'b0);
        send_beat(PRINT_LO, 1'b0);
        send_beat(PRINT_HI, 1'b0);
        send_beat(CH_EQ, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h7f, 1'b0);
        // held space followed by a plain byte passes literally
        send_beat(CH_SPACE, 1'b0);
        send_beat(8'h62, 1'b0);
        // held whitespace before a line end gets escaped
        send_beat(CH_TAB, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_TAB, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_beat(CH_LF, 1'b0);
        // lone cr yields nothing
        send_beat(CH_CR, 1'b0);
        // whitespace as the last byte of a text
        send_beat(CH_SPACE, 1'b1);
        send_beat(CH_TAB, 1'b0);
        send_beat(8'h7a, 1'b1);
        // a text that ends on a dropped cr, so no beat carries text_end
        send_beat(CH_CR, 1'b1);
        send_beat(8'h80, 1'b1);
        send_beat(CH_TAB, 1'b0);
        send_beat(CH_LF, 1'b1);

        // random texts under several line widths, extremes included
        for (int p = 0; p < PHASES; p++) begin
            drain_and_settle();
            if (p == 3 || p == 4) begin
                set_width(8'($urandom_range(6, 120)));
            end else begin
                set_width(phase_width[p]);
            end
            gap_free    <= (p == 2 || p == 5);
            sink_steady <= (p == 2 || p == 5);
            send_text(15);
            // full drain in the middle of a text
            if (p == 1) begin
                drain_and_settle();
            end
            send_text(15);
        end

        drain_and_settle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
